### design/sidm_pkg.sv
// Shared constants, request codes and handshake structs for the sorted ID set block.
// No dependencies; sidm_search and the top level refer to it by scoped names.
package sidm_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ID_BITS     = 20;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int MISS_W      = 16;
  localparam int LIMIT_W     = 11;
  localparam int ID_TDATA_W  = ((ID_BITS + 7) / 8) * 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
  localparam logic [MISS_W-1:0]  MISS_MAX    = '1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    logic               start;
    logic               insert;
    logic [ID_BITS-1:0] key;
    logic [CNT_W-1:0]   count;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic absent;
  } srch_rsp_t;

endpackage

### design/sidm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module sidm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/sidm_search.sv
// Sequencer over the ID store: binary search, membership check and sorted insert
// with entry shifting. Depends on sidm_pkg; drives the ports of sidm_ram.
module sidm_search (
  input  logic                              clk,
  input  logic                              rst,
  input  sidm_pkg::srch_req_t               req,
  output sidm_pkg::srch_rsp_t               rsp,
  output logic                              ram_re,
  output logic [sidm_pkg::ADDR_W-1:0]       ram_raddr,
  input  logic [sidm_pkg::ID_BITS-1:0]      ram_rdata,
  output logic                              ram_we,
  output logic [sidm_pkg::ADDR_W-1:0]       ram_waddr,
  output logic [sidm_pkg::ID_BITS-1:0]      ram_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SRCH_RD  = 7'b0000010,
    ST_SRCH_CMP = 7'b0000100,
    ST_CHK_CMP  = 7'b0001000,
    ST_SHIFT_RD = 7'b0010000,
    ST_SHIFT_WR = 7'b0100000,
    ST_PUT      = 7'b1000000
  } state_t;

  state_t                          state;
  logic [sidm_pkg::CNT_W-1:0]      lo;
  logic [sidm_pkg::CNT_W-1:0]      hi;
  logic [sidm_pkg::CNT_W-1:0]      mid;
  logic [sidm_pkg::CNT_W-1:0]      idx;
  logic [sidm_pkg::CNT_W-1:0]      count;
  logic [sidm_pkg::ID_BITS-1:0]    key;
  logic                            insert;

  logic [sidm_pkg::CNT_W-1:0]      mid_c;
  logic [sidm_pkg::CNT_W-1:0]      idx_dec;
  logic                            go_right;

  assign mid_c    = lo + ((hi - lo) >> 1);
  assign idx_dec  = idx - sidm_pkg::CNT_W'(1);
  assign go_right = insert ? (ram_rdata <= key) : (ram_rdata < key);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = mid_c[sidm_pkg::ADDR_W-1:0];
    case (state)
      ST_SRCH_RD: begin
        if (lo < hi) begin
          ram_re = 1'b1;
        end else begin
          ram_re    = !insert && (lo < count);
          ram_raddr = lo[sidm_pkg::ADDR_W-1:0];
        end
      end
      ST_SHIFT_RD: begin
        ram_re    = idx > lo;
        ram_raddr = idx_dec[sidm_pkg::ADDR_W-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  assign ram_we    = (state == ST_SHIFT_WR) || (state == ST_PUT);
  assign ram_waddr = (state == ST_SHIFT_WR) ? idx[sidm_pkg::ADDR_W-1:0]
                                            : lo[sidm_pkg::ADDR_W-1:0];
  assign ram_wdata = (state == ST_SHIFT_WR) ? ram_rdata : key;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp   <= '0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            lo     <= '0;
            hi     <= req.count;
            count  <= req.count;
            key    <= req.key;
            insert <= req.insert;
            state  <= ST_SRCH_RD;
          end
        end
        ST_SRCH_RD: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= ST_SRCH_CMP;
          end else if (insert) begin
            idx   <= count;
            state <= ST_SHIFT_RD;
          end else if (lo < count) begin
            state <= ST_CHK_CMP;
          end else begin
            rsp.done   <= 1'b1;
            rsp.absent <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        ST_SRCH_CMP: begin
          if (go_right) begin
            lo <= mid + sidm_pkg::CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= ST_SRCH_RD;
        end
        ST_CHK_CMP: begin
          rsp.done   <= 1'b1;
          rsp.absent <= ram_rdata != key;
          state      <= ST_IDLE;
        end
        ST_SHIFT_RD: begin
          state <= (idx > lo) ? ST_SHIFT_WR : ST_PUT;
        end
        ST_SHIFT_WR: begin
          idx   <= idx_dec;
          state <= ST_SHIFT_RD;
        end
        ST_PUT: begin
          rsp.done   <= 1'b1;
          rsp.absent <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/sorted_id_set_miss_counter.sv
// Top level of the sorted ID set: request intake, run miss total, result register.
// Depends on sidm_pkg, sidm_ram and sidm_search.
//
//  channel  | direction | tdata            | tuser                   | tlast
//  ---------+-----------+------------------+-------------------------+---------
//  s_       | in        | value_id         | req_type                | run_last
//  m_       | out       | miss_count       | is_full, status         | run_done
//  cfg_     | in        | size_limit (write enable and data, no wait)
//
// One item at a time; input reopens at the result register load.
// A lookup or run element does a binary search of k <= ceil(log2(n+1)) halving steps
// for n stored IDs, one RAM read each, then a check read unless the key is above all IDs.
// An insert searches likewise, moves the m entries above its slot up one place and
// writes the key; a refused insert (store full) or an unused code starts no search.
// Reset is synchronous and clears the count, run total and size limit (to 1024).
// A held result in the output register does not block intake; a second one behind it does.
module sorted_id_set_miss_counter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sidm_pkg::LIMIT_W-1:0]       cfg_data,    // size_limit
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sidm_pkg::ID_TDATA_W-1:0]    s_tdata,     // value_id, zero pad
  input  logic [1:0]                         s_tuser,     // req_type
  input  logic                               s_tlast,     // run_last
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sidm_pkg::MISS_W-1:0]        m_tdata,     // miss_count
  output logic [1:0]                         m_tuser,     // is_full, status
  output logic                               m_tlast      // run_done
);

  logic [sidm_pkg::LIMIT_W-1:0]  size_limit;
  logic [sidm_pkg::CNT_W-1:0]    count;
  logic [sidm_pkg::CNT_W-1:0]    count_inc;
  logic [sidm_pkg::MISS_W-1:0]   run_total;
  logic [sidm_pkg::MISS_W-1:0]   run_total_next;
  logic                          busy;
  sidm_pkg::req_t                req_q;
  sidm_pkg::req_t                s_req;
  logic                          last_q;

  logic                          res_pend;
  logic [sidm_pkg::MISS_W-1:0]   res_miss;
  logic                          res_done;
  logic                          res_full;
  logic                          res_status;

  logic                          accept;
  logic                          store_full;
  logic                          needs_search;
  logic                          out_load;

  sidm_pkg::srch_req_t           sreq;
  sidm_pkg::srch_rsp_t           srsp;

  logic                          ram_re;
  logic [sidm_pkg::ADDR_W-1:0]   ram_raddr;
  logic [sidm_pkg::ID_BITS-1:0]  ram_rdata;
  logic                          ram_we;
  logic [sidm_pkg::ADDR_W-1:0]   ram_waddr;
  logic [sidm_pkg::ID_BITS-1:0]  ram_wdata;

  assign s_tready   = !busy;
  assign accept     = s_tvalid && s_tready;
  assign s_req      = sidm_pkg::req_t'(s_tuser);
  assign store_full = count == sidm_pkg::CNT_W'(sidm_pkg::STORE_DEPTH);
  assign count_inc  = count + sidm_pkg::CNT_W'(1);
  assign out_load   = res_pend && (!m_tvalid || m_tready);

  always_comb begin
    needs_search = 1'b0;
    if (s_req inside {sidm_pkg::REQ_LOOKUP, sidm_pkg::REQ_RUN}) begin
      needs_search = 1'b1;
    end else if (s_req == sidm_pkg::REQ_INSERT) begin
      needs_search = !store_full;
    end
  end

  assign sreq.start  = accept && needs_search;
  assign sreq.insert = s_req == sidm_pkg::REQ_INSERT;
  assign sreq.key    = s_tdata[sidm_pkg::ID_BITS-1:0];
  assign sreq.count  = count;

  assign run_total_next = (run_total == sidm_pkg::MISS_MAX) ? run_total
                        : run_total + sidm_pkg::MISS_W'(srsp.absent);

  sidm_search u_search (
    .clk       (clk),
    .rst       (rst),
    .req       (sreq),
    .rsp       (srsp),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  sidm_ram #(
    .DEPTH (sidm_pkg::STORE_DEPTH),
    .WIDTH (sidm_pkg::ID_BITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= sidm_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      size_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      run_total <= '0;
      busy      <= 1'b0;
      res_pend  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        busy   <= 1'b1;
        req_q  <= s_req;
        last_q <= s_tlast;
        if (!needs_search) begin
          res_pend   <= 1'b1;
          res_miss   <= '0;
          res_done   <= 1'b0;
          res_full   <= 32'(count) == 32'(size_limit);
          res_status <= s_req == sidm_pkg::REQ_INSERT;
        end
      end
      if (srsp.done) begin
        res_pend   <= 1'b1;
        res_status <= 1'b0;
        res_done   <= 1'b0;
        res_miss   <= '0;
        res_full   <= 32'(count) == 32'(size_limit);
        case (req_q)
          sidm_pkg::REQ_INSERT: begin
            count    <= count_inc;
            res_full <= 32'(count_inc) == 32'(size_limit);
          end
          sidm_pkg::REQ_LOOKUP: begin
            res_miss <= sidm_pkg::MISS_W'(srsp.absent);
          end
          sidm_pkg::REQ_RUN: begin
            res_miss  <= run_total_next;
            res_done  <= last_q;
            run_total <= last_q ? '0 : run_total_next;
          end
          default: begin
            res_miss <= '0;
          end
        endcase
      end
      if (out_load) begin
        res_pend   <= 1'b0;
        busy       <= 1'b0;
        m_tvalid   <= 1'b1;
        m_tdata    <= res_miss;
        m_tlast    <= res_done;
        m_tuser[0] <= res_full;
        m_tuser[1] <= res_status;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= sidm_pkg::STORE_DEPTH)
    else $error("stored count above store depth");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    srsp.done |-> busy && !res_pend)
    else $error("search finished with no item in flight or a result still held");

  a_refuse_only_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> store_full)
    else $error("insert refused while store has room");

  a_run_close_not_refused: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser[1])
    else $error("closing run beat flagged as refused insert");

endmodule
